// ----- sv/brr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package brr_pkg;

  // Line capacity and field widths
  localparam int MAX_RUNS = 32;
  localparam int LVL_W    = 7;
  localparam int IDX_W    = $clog2(MAX_RUNS);
  localparam int CNT_W    = $clog2(MAX_RUNS + 1);
  localparam int WID_W    = 24;
  localparam int ORG_W    = 29;
  localparam int POS_W    = 5;
  localparam int LOW_W    = 8;

  // Lowest-level tracker value while no run is stored
  localparam logic [LOW_W-1:0] NO_LEVEL = 8'hFF;

  // One entry of the visual order store: run level travels with its index
  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [IDX_W-1:0] idx;
  } perm_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_PREP,
    S_LVL_START,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_RUN_RD,
    S_RUN_CHK,
    S_SWAP_RD,
    S_SWAP_W0,
    S_SWAP_W1,
    S_LVL_NEXT,
    S_EMIT_RD,
    S_EMIT_WRD,
    S_EMIT_OUT
  } brr_state_e;

endpackage

`default_nettype wire

// ----- sv/brr_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one text run per transaction
interface brr_in_if;
  import brr_pkg::*;

  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] direction_level;
  logic [WID_W-1:0] run_width;
  logic             final_run;

  modport source (output valid, output direction_level, output run_width,
                  output final_run, input ready);
  modport sink   (input valid, input direction_level, input run_width,
                  input final_run, output ready);
endinterface

// Output channel: one visually placed run per transaction
interface brr_out_if;
  import brr_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] visual_position;
  logic [POS_W-1:0] logical_index;
  logic [ORG_W-1:0] origin;
  logic             final_result;

  modport source (output valid, output visual_position, output logical_index,
                  output origin, output final_result, input ready);
  modport sink   (input valid, input visual_position, input logical_index,
                  input origin, input final_result, output ready);
endinterface

`default_nettype wire

// ----- sv/bidi_run_reorder_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                            Meaning
// in_i      in   direction_level, run_width, final_run              one run, logical order
// out_o     out  visual_position, logical_index, origin, final_result one run, visual order
//
// Sequence: runs that are not final are stored while the input stays ready. The final
// run starts the reorder sequencer: setup, then per level from the highest down to the
// lowest odd level a scan for each stretch at or above the level, a swap pass that
// reverses it and a rescan of a lower run that ends it, all
// bound by the single read/compare path. Emission then offers each run in visual order, holding through a stall.
// Reset clears the run count and the level trackers; the stores need no reset.
// The input is not ready from the final run until the last result is taken.

module bidi_run_reorder_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  brr_in_if.sink    in_i,
  brr_out_if.source out_o
);
  import brr_pkg::*;

  // Stores
  perm_t            perm_mem  [MAX_RUNS];
  logic [WID_W-1:0] width_mem [MAX_RUNS];

  // Sequencer and working registers
  brr_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [LVL_W-1:0] hi_lvl_q, hi_lvl_d;
  logic [LOW_W-1:0] lo_lvl_q, lo_lvl_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic [IDX_W-1:0] lo_q, lo_d;
  logic [IDX_W-1:0] hi_q, hi_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [ORG_W-1:0] org_q, org_d;

  // Registered read data
  perm_t            rd0_q, rd1_q;
  logic [WID_W-1:0] wid_q;

  // Control from the sequencer
  logic             in_ready, out_valid;
  logic             rd0_en, rd1_en, wid_re, wid_we, we;
  logic [IDX_W-1:0] rd0_addr, rd1_addr, waddr;
  perm_t            wdata;

  // Shared compare and status terms
  logic             accept, out_hs, store_ok, lvl_ge, emit_last, at_end, below_floor;
  logic [LOW_W-1:0] floor_odd;

  assign accept      = in_i.valid && in_ready;
  assign out_hs      = out_valid && out_o.ready;
  assign store_ok    = cnt_q < CNT_W'(MAX_RUNS);
  assign lvl_ge      = rd0_q.level >= lvl_q;
  assign emit_last   = CNT_W'(k_q + CNT_W'(1)) == cnt_q;
  assign at_end      = j_q == cnt_q;
  assign floor_odd   = lo_lvl_q | LOW_W'(1);
  assign below_floor = LOW_W'(lvl_q) < floor_odd;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD:      if (accept && in_i.final_run) state_d = S_PREP;
      S_PREP:      state_d = S_LVL_START;
      S_LVL_START: state_d = below_floor ? S_EMIT_RD : S_SCAN_RD;
      S_SCAN_RD:   state_d = at_end ? S_LVL_NEXT : S_SCAN_CHK;
      S_SCAN_CHK:  state_d = lvl_ge ? S_RUN_RD : S_SCAN_RD;
      S_RUN_RD:    state_d = at_end ? S_SWAP_RD : S_RUN_CHK;
      S_RUN_CHK:   state_d = lvl_ge ? S_RUN_RD : S_SWAP_RD;
      S_SWAP_RD:   state_d = (lo_q < hi_q) ? S_SWAP_W0 : S_SCAN_RD;
      S_SWAP_W0:   state_d = S_SWAP_W1;
      S_SWAP_W1:   state_d = S_SWAP_RD;
      S_LVL_NEXT:  state_d = S_LVL_START;
      S_EMIT_RD:   state_d = S_EMIT_WRD;
      S_EMIT_WRD:  state_d = S_EMIT_OUT;
      S_EMIT_OUT:  if (out_hs) state_d = emit_last ? S_LOAD : S_EMIT_RD;
      default:     state_d = S_LOAD;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    rd0_en    = 1'b0;
    rd1_en    = 1'b0;
    rd0_addr  = j_q[IDX_W-1:0];
    rd1_addr  = hi_q;
    wid_re    = 1'b0;
    wid_we    = 1'b0;
    we        = 1'b0;
    waddr     = cnt_q[IDX_W-1:0];
    wdata     = '{level: in_i.direction_level, idx: cnt_q[IDX_W-1:0]};
    cnt_d     = cnt_q;
    hi_lvl_d  = hi_lvl_q;
    lo_lvl_d  = lo_lvl_q;
    lvl_d     = lvl_q;
    j_d       = j_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    k_d       = k_q;
    org_d     = org_q;
    case (state_q)
      S_LOAD: begin
        in_ready = 1'b1;
        // Store the run with its index as the initial visual order; drop it when full
        if (accept && store_ok) begin
          we     = 1'b1;
          wid_we = 1'b1;
          cnt_d  = CNT_W'(cnt_q + CNT_W'(1));
          if (in_i.direction_level > hi_lvl_q) hi_lvl_d = in_i.direction_level;
          if (LOW_W'(in_i.direction_level) < lo_lvl_q) begin
            lo_lvl_d = LOW_W'(in_i.direction_level);
          end
        end
      end
      S_PREP: begin
        lvl_d = hi_lvl_q;
      end
      S_LVL_START: begin
        j_d   = '0;
        k_d   = '0;
        org_d = '0;
      end
      S_SCAN_RD: begin
        rd0_en = !at_end;
      end
      S_SCAN_CHK: begin
        // Open a stretch at the first run at or above the level
        if (lvl_ge) lo_d = j_q[IDX_W-1:0];
        j_d = CNT_W'(j_q + CNT_W'(1));
      end
      S_RUN_RD: begin
        rd0_en = !at_end;
        if (at_end) hi_d = IDX_W'(j_q - CNT_W'(1));
      end
      S_RUN_CHK: begin
        if (lvl_ge) j_d  = CNT_W'(j_q + CNT_W'(1));
        else        hi_d = IDX_W'(j_q - CNT_W'(1));
      end
      S_SWAP_RD: begin
        rd0_addr = lo_q;
        rd0_en   = lo_q < hi_q;
        rd1_en   = lo_q < hi_q;
      end
      S_SWAP_W0: begin
        we    = 1'b1;
        waddr = lo_q;
        wdata = rd1_q;
      end
      S_SWAP_W1: begin
        we    = 1'b1;
        waddr = hi_q;
        wdata = rd0_q;
        lo_d  = IDX_W'(lo_q + IDX_W'(1));
        hi_d  = IDX_W'(hi_q - IDX_W'(1));
      end
      S_LVL_NEXT: begin
        lvl_d = LVL_W'(lvl_q - LVL_W'(1));
      end
      S_EMIT_RD: begin
        rd0_addr = k_q[IDX_W-1:0];
        rd0_en   = 1'b1;
      end
      S_EMIT_WRD: begin
        wid_re = 1'b1;
      end
      S_EMIT_OUT: begin
        out_valid = 1'b1;
        if (out_hs) begin
          org_d = ORG_W'(org_q + ORG_W'(wid_q));
          k_d   = CNT_W'(k_q + CNT_W'(1));
          // Close the line after its last result
          if (emit_last) begin
            cnt_d    = '0;
            hi_lvl_d = '0;
            lo_lvl_d = NO_LEVEL;
          end
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      cnt_q    <= '0;
      hi_lvl_q <= '0;
      lo_lvl_q <= NO_LEVEL;
      lvl_q    <= '0;
      j_q      <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      k_q      <= '0;
      org_q    <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      hi_lvl_q <= hi_lvl_d;
      lo_lvl_q <= lo_lvl_d;
      lvl_q    <= lvl_d;
      j_q      <= j_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      k_q      <= k_d;
      org_q    <= org_d;
    end
  end

  // Visual order store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we)     perm_mem[waddr] <= wdata;
    if (rd0_en) rd0_q <= perm_mem[rd0_addr];
    if (rd1_en) rd1_q <= perm_mem[rd1_addr];
  end

  // Width store: written at load, read by logical index during emission
  always_ff @(posedge clk_i) begin
    if (wid_we) width_mem[cnt_q[IDX_W-1:0]] <= in_i.run_width;
    if (wid_re) wid_q <= width_mem[rd0_q.idx];
  end

  assign in_i.ready            = in_ready;
  assign out_o.valid           = out_valid;
  assign out_o.visual_position = POS_W'(k_q);
  assign out_o.logical_index   = POS_W'(rd0_q.idx);
  assign out_o.origin          = org_q;
  assign out_o.final_result    = emit_last;

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid))
    else $error("input taken while a result is offered");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> cnt_q != '0)
    else $error("result offered with an empty line");

  a_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_hs && emit_last) |=> (cnt_q == '0 && lo_lvl_q == NO_LEVEL && hi_lvl_q == '0))
    else $error("line state not cleared after last result");

  a_swap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SWAP_W0 |-> lo_q < hi_q)
    else $error("swap with crossed bounds");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    j_q <= cnt_q)
    else $error("scan pointer past the line");
`endif

endmodule

`default_nettype wire

// ----- tb/bidi_run_reorder_core_checker.sv -----
`timescale 1ns / 1ps

// Watch both channels, rebuild each line's visual order and compare every
// placed run against it in arrival order.
module bidi_run_reorder_core_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  brr_in_if           in_i,
  brr_out_if          out_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned placed_o
);
  import brr_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] idx;
    logic [ORG_W-1:0] origin;
    logic             last;
  } placement_t;

  logic [LVL_W-1:0] line_level [MAX_RUNS];
  logic [WID_W-1:0] line_width [MAX_RUNS];
  int unsigned      line_len     = 0;
  logic [LVL_W-1:0] top_level    = '0;
  logic [LOW_W-1:0] bottom_level = NO_LEVEL;
  placement_t       placements_q [$];
  int unsigned      fails  = 0;
  int unsigned      placed = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    placed_o     = 0;
  end

  // Reverse every stretch at or above each level, highest level first, then
  // queue the runs in visual order with their running origin.
  task automatic queue_visual_order();
    logic [IDX_W-1:0] order [MAX_RUNS];
    logic [IDX_W-1:0] swap;
    logic [ORG_W-1:0] org;
    int               n, k, j, len, lo, hi, lvl, floor_odd;
    placement_t       p;
    n = int'(line_len);
    for (k = 0; k < n; k++) order[k] = IDX_W'(k);
    floor_odd = int'(bottom_level | 8'd1);
    for (lvl = int'(top_level); lvl >= floor_odd; lvl--) begin
      j = 0;
      while (j < n) begin
        if (int'(line_level[order[j]]) < lvl) begin
          j++;
        end else begin
          len = 0;
          while (j + len < n && int'(line_level[order[j + len]]) >= lvl) len++;
          lo = j;
          hi = j + len - 1;
          while (lo < hi) begin
            swap      = order[lo];
            order[lo] = order[hi];
            order[hi] = swap;
            lo++;
            hi--;
          end
          j += len;
        end
      end
    end
    org = '0;
    for (k = 0; k < n; k++) begin
      p.pos    = POS_W'(k);
      p.idx    = POS_W'(order[k]);
      p.origin = org;
      p.last   = (k == n - 1);
      placements_q.push_back(p);
      org = org + ORG_W'(line_width[order[k]]);
    end
  endtask

  task automatic take_run();
    if (line_len < MAX_RUNS) begin
      line_level[line_len] = in_i.direction_level;
      line_width[line_len] = in_i.run_width;
      line_len++;
      if (in_i.direction_level > top_level) top_level = in_i.direction_level;
      if (LOW_W'(in_i.direction_level) < bottom_level) begin
        bottom_level = LOW_W'(in_i.direction_level);
      end
    end
    if (in_i.final_run) begin
      queue_visual_order();
      line_len     = 0;
      top_level    = '0;
      bottom_level = NO_LEVEL;
    end
  endtask

  task automatic match_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_placement();
    placement_t want;
    placed++;
    if (placements_q.size() == 0) begin
      fails++;
      $display("%0t: unexpected result, expected none actual pos %0d idx %0d origin %0d",
               $time, out_i.visual_position, out_i.logical_index, out_i.origin);
    end else begin
      want = placements_q.pop_front();
      match_field("visual_position", want.pos, out_i.visual_position);
      match_field("logical_index", want.idx, out_i.logical_index);
      match_field("origin", want.origin, out_i.origin);
      match_field("final_result", want.last, out_i.final_result);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len     = 0;
      top_level    = '0;
      bottom_level = NO_LEVEL;
      placements_q.delete();
    end else begin
      if (out_i.valid && out_i.ready) check_placement();
      if (in_i.valid && in_i.ready) take_run();
    end
    fail_count_o <= fails;
    pending_o    <= placements_q.size();
    placed_o     <= placed;
  end

endmodule

// ----- tb/bidi_run_reorder_core_test.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the bidi run reorder core. The checker beside the
// block does all prediction and comparison; this module only feeds lines of
// runs, toggles backpressure and decides pass or fail.
module bidi_run_reorder_core_test;
  import brr_pkg::*;

  // Worst line is 32 runs over 127 levels; the limit leaves room for that
  // on top of heavily throttled traffic.
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned PHASE_RUNS   = 76;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  brr_in_if  in_bus ();
  brr_out_if out_bus ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned placed;

  int unsigned runs_sent      = 0;
  int unsigned lines_sent     = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned take_stall_pct = 0;

  // Idling mix per random phase: free flow, sparse sender, slow receiver,
  // light jitter on both sides.
  int unsigned idle_by_phase  [4] = '{0, 86, 0, 11};
  int unsigned stall_by_phase [4] = '{0, 0, 86, 11};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  bidi_run_reorder_core u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  bidi_run_reorder_core_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_bus),
    .out_i       (out_bus),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .placed_o    (placed)
  );

  // Receiver: hold ready low at random by the current stall rate.
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_bus.ready <= ($urandom_range(99) >= take_stall_pct);
    end
  end

  // Present one run, idling first at the current rate, and hold it until the
  // transaction completes. Valid stays high into the next call.
  task automatic send_run(input logic [LVL_W-1:0] lvl, input logic [WID_W-1:0] wid,
                          input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid           <= 1'b1;
    in_bus.direction_level <= lvl;
    in_bus.run_width       <= wid;
    in_bus.final_run       <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    runs_sent++;
    if (last) lines_sent++;
  endtask

  // Mostly well-formed lines: a base direction with nested embeddings a few
  // levels deep. A few short lines take any level, a few overflow the store
  // so the tail runs, the final one included, get dropped.
  task automatic send_random_line();
    int unsigned      pick, n, base, k;
    logic             wild;
    logic [LVL_W-1:0] lvl;
    logic [WID_W-1:0] wid;
    pick = $urandom_range(99);
    if (pick < 6)       n = $urandom_range(36, MAX_RUNS + 1);
    else if (pick < 26) n = $urandom_range(MAX_RUNS, 9);
    else                n = $urandom_range(8, 1);
    wild = (n <= 4) && ($urandom_range(5) == 0);
    base = $urandom_range(1);
    for (k = 0; k < n; k++) begin
      if (wild) lvl = LVL_W'($urandom_range((1 << LVL_W) - 1));
      else      lvl = LVL_W'(base + $urandom_range(3));
      case ($urandom_range(7))
        0:       wid = '0;
        1:       wid = '1;
        default: wid = WID_W'($urandom);
      endcase
      send_run(lvl, wid, k == n - 1);
    end
  endtask

  initial begin
    int unsigned k, phase;

    in_bus.valid           <= 1'b0;
    in_bus.direction_level <= '0;
    in_bus.run_width       <= '0;
    in_bus.final_run       <= 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines, no idling.
    // Lone run at level zero: no odd level to reach, order unchanged.
    send_run(7'd0, 24'h000000, 1'b1);
    // Lone run at the highest out-of-range level, full width.
    send_run(7'd127, 24'hFFFFFF, 1'b1);
    // Even levels only: lowest odd level sits above the highest level.
    send_run(7'd2, 24'h000100, 1'b0);
    send_run(7'd2, 24'h000080, 1'b0);
    send_run(7'd2, 24'h000001, 1'b1);
    // Nested embeddings ending on the other out-of-range level.
    send_run(7'd0, 24'h012345, 1'b0);
    send_run(7'd1, 24'h00FF00, 1'b0);
    send_run(7'd2, 24'h7FFFFF, 1'b0);
    send_run(7'd1, 24'h000010, 1'b0);
    send_run(7'd126, 24'hFFFFFF, 1'b1);
    // Deep levels next to a left-to-right run.
    send_run(7'd125, 24'hAAAAAA, 1'b0);
    send_run(7'd124, 24'h555555, 1'b0);
    send_run(7'd127, 24'hFFFFFF, 1'b0);
    send_run(7'd0, 24'h800000, 1'b1);
    // Plain right-to-left line: full reversal.
    send_run(7'd1, 24'h000001, 1'b0);
    send_run(7'd1, 24'h000002, 1'b0);
    send_run(7'd1, 24'h000003, 1'b0);
    send_run(7'd1, 24'h000004, 1'b1);
    // Full line at full width for the largest origin; the final run lands
    // past capacity and is dropped, yet still closes the line.
    for (k = 0; k <= MAX_RUNS; k++) begin
      send_run(LVL_W'($urandom_range(3)), 24'hFFFFFF, k == MAX_RUNS);
    end

    // Random lines, one idling mix per phase.
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = idle_by_phase[phase];
      take_stall_pct = stall_by_phase[phase];
      k = runs_sent + PHASE_RUNS;
      while (runs_sent < k) send_random_line();
    end

    // Drop valid, then wait for every placement to come back and let the
    // block settle.
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d lines, %0d runs sent, %0d placements checked", lines_sent,
             runs_sent, placed);
    $display("levels 0 to 127, zero and full widths, dropped runs past a full line");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d results still due", $time,
             cycle_count, pending);
    $display("tb: failure");
    $finish;
  end

endmodule
